// File: rtl/prime_test_32bit_defines.svh
// Assertion macros used by the prime tester controller.
// Depends on nothing; included by modules that carry assertions.
`ifndef PRIME_TEST_32BIT_DEFINES_SVH
`define PRIME_TEST_32BIT_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define PT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define PT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/pt_pkg.sv
// Package for the prime tester: limits, state encoding and command/status types.
// Depends on nothing.
`default_nettype none
package pt_pkg;
  localparam int unsigned SieveSize = 65536;
  localparam logic [31:0] LimitTwo   = 32'd1000000;
  localparam logic [31:0] LimitThree = 32'd25000000;
  localparam logic [31:0] LimitFour  = 32'd3000000000;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_SIEVE_SCAN, ST_SIEVE_CHECK, ST_SIEVE_MARK, ST_IDLE, ST_LOOKUP,
    ST_ROUND_START, ST_POW, ST_SQUARE, ST_DONE, ST_OUT
  } state_e;

  // Phases of the multiply-reduce unit.
  typedef enum logic [1:0] {MM_IDLE, MM_MUL, MM_RED} mm_phase_e;

  // Product that the datapath is waiting for.
  typedef enum logic [1:0] {OP_NONE, OP_ACC, OP_BASE, OP_SQUARE} mm_op_e;

  // Commands from the controller to the modular arithmetic datapath.
  typedef struct packed {
    logic       load;       // capture number, compute d and s
    logic       start_round; // begin a round with the given witness
    logic [2:0] witness;
    logic       pow_step;   // one square-and-multiply step
    logic       sq_step;    // one squaring of y
  } dp_cmd_t;

  typedef struct packed {
    logic busy;       // multiplier/reducer working
    logic pow_done;   // exponent exhausted
    logic y_pass;     // y == 1 or y == n-1 (after pow)
    logic y_minus1;   // y == n-1
    logic s_zero;     // no squarings left
  } dp_sts_t;
endpackage
`default_nettype wire

// File: rtl/pt_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing.
`default_nettype none
interface pt_if #(parameter int unsigned W = 1) (input wire logic clk_i);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/pt_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module pt_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: rtl/pt_mulmod.sv
// Multi-cycle (a*b) mod n unit: 32x32 product then bit-serial restoring reduction.
// Depends on pt_pkg.
`default_nettype none
module pt_mulmod (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [31:0] n_i,
  output logic             busy_o,
  output logic             done_o,
  output logic      [31:0] r_o
);
  import pt_pkg::*;
  logic [63:0] prod_q, prod_d;
  logic [32:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  mm_phase_e   ph_q, ph_d;
  logic        done_q, done_d;
  logic [32:0] sh;

  always_comb begin
    prod_d = prod_q; rem_d = rem_q; cnt_d = cnt_q; ph_d = ph_q; done_d = 1'b0;
    sh = '0;
    case (ph_q)
      MM_IDLE: if (start_i) begin
        prod_d = {32'd0, a_i} * {32'd0, b_i};
        ph_d = MM_MUL;
      end
      MM_MUL: begin
        rem_d = '0; cnt_d = 7'd64; ph_d = MM_RED;
      end
      MM_RED: begin
        // One quotient bit per cycle; remainder stays below n.
        sh = {rem_q[31:0], prod_q[63]};
        if (sh >= {1'b0, n_i}) sh = sh - {1'b0, n_i};
        rem_d = sh;
        prod_d = {prod_q[62:0], 1'b0};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          ph_d = MM_IDLE; done_d = 1'b1;
        end
      end
      default: ph_d = MM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= MM_IDLE; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      ph_q <= ph_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d; rem_q <= rem_d;
  end

  assign busy_o = (ph_q != MM_IDLE);
  assign done_o = done_q;
  assign r_o = rem_q[31:0];
endmodule
`default_nettype wire

// File: rtl/pt_datapath.sv
// Miller-Rabin datapath: holds n, d, s, y, exponent and base; uses pt_mulmod.
// Depends on pt_pkg and pt_mulmod.
`default_nettype none
module pt_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [31:0]     number_i,
  input  wire pt_pkg::dp_cmd_t cmd_i,
  output pt_pkg::dp_sts_t      sts_o
);
  import pt_pkg::*;
  logic [31:0] n_q, d_q, e_q, y_q, b_q, d_d, dm1;
  logic [4:0]  s_d, s0_q, sc_q;
  logic        tz_found;
  mm_op_e      op_q;
  logic        pend_q;        // b*b still owed in this pow step
  logic        mm_start;
  logic [31:0] mm_a, mm_b, mm_r;
  logic        mm_busy, mm_done;

  // n - 1 splits into d times a power of two: find the lowest set bit, then shift.
  always_comb begin
    dm1 = number_i - 32'd1;
    s_d = '0; tz_found = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!tz_found && dm1[i]) begin
        s_d = 5'(i); tz_found = 1'b1;
      end
    end
    d_d = dm1 >> s_d;
  end

  always_comb begin
    mm_start = 1'b0; mm_a = y_q; mm_b = b_q;
    if (cmd_i.pow_step) begin
      mm_start = 1'b1;
      if (e_q[0]) begin mm_a = y_q; mm_b = b_q; end
      else begin mm_a = b_q; mm_b = b_q; end
    end else if (cmd_i.sq_step) begin
      mm_start = 1'b1; mm_a = y_q; mm_b = y_q;
    end else if (pend_q && !mm_busy) begin
      mm_start = 1'b1; mm_a = b_q; mm_b = b_q;
    end
  end

  pt_mulmod u_mm (
    .clk_i, .rst_ni, .start_i(mm_start), .a_i(mm_a), .b_i(mm_b), .n_i(n_q),
    .busy_o(mm_busy), .done_o(mm_done), .r_o(mm_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NONE; pend_q <= 1'b0;
    end else begin
      if (mm_done) begin
        case (op_q)
          OP_ACC: pend_q <= 1'b1;
          default: ;
        endcase
        op_q <= OP_NONE;
      end
      if (cmd_i.pow_step) begin
        op_q <= e_q[0] ? OP_ACC : OP_BASE;
      end else if (cmd_i.sq_step) begin
        op_q <= OP_SQUARE;
      end else if (pend_q && !mm_busy) begin
        op_q <= OP_BASE; pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= number_i; d_q <= d_d;
    end
    if (cmd_i.start_round) begin
      y_q <= 32'd1; b_q <= {29'd0, cmd_i.witness}; e_q <= d_q;
    end
    if (mm_done) begin
      case (op_q)
        OP_ACC: y_q <= mm_r;
        OP_BASE: begin b_q <= mm_r; e_q <= e_q >> 1; end
        OP_SQUARE: y_q <= mm_r;
        default: ;
      endcase
    end
  end

  // s is consumed per round, so keep a copy to restore at each round start.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) s0_q <= s_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_round) sc_q <= s0_q;
    else if (mm_done && op_q == OP_SQUARE) sc_q <= sc_q - 5'd1;
  end

  assign sts_o.busy     = mm_busy || mm_done || pend_q || (op_q != OP_NONE);
  assign sts_o.pow_done = (e_q == 32'd0);
  assign sts_o.y_pass   = (y_q == 32'd1) || (y_q == n_q - 32'd1);
  assign sts_o.y_minus1 = (y_q == n_q - 32'd1);
  assign sts_o.s_zero   = (sc_q == 5'd0);
endmodule
`default_nettype wire

// File: rtl/pt_ctrl.sv
// Controller: sieve fill after reset, table lookup and Miller-Rabin round sequencing.
// Depends on pt_pkg, pt_ram and the assertion header.
`default_nettype none
`include "prime_test_32bit_defines.svh"
module pt_ctrl #(
  parameter int unsigned SieveSize = pt_pkg::SieveSize
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [31:0]     number_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 is_prime_o,
  output logic                 out_of_range_o,
  output pt_pkg::dp_cmd_t      cmd_o,
  input  wire pt_pkg::dp_sts_t sts_i
);
  import pt_pkg::*;
  localparam int unsigned AW = $clog2(SieveSize);

  state_e state_q, state_d;
  logic [AW:0] i_q, i_d, j_q, j_d;
  logic [31:0] num_q, num_d;
  logic [1:0]  rnd_q, rnd_d;  // 0: witness 2, 1: 3, 2: 5, 3: 7
  logic        prime_q, prime_d, oor_q, oor_d;
  logic        we;
  logic [AW-1:0] addr;
  logic        wdata, rdata;

  pt_ram #(.Width(1), .Depth(SieveSize)) u_sieve (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q; i_d = i_q; j_d = j_q; num_d = num_q; rnd_d = rnd_q;
    prime_d = prime_q; oor_d = oor_q;
    we = 1'b0; wdata = 1'b0; addr = i_q[AW-1:0];
    cmd_o = '0; cmd_o.witness = 3'd2;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1; wdata = (i_q > (AW+1)'(1));
        i_d = i_q + 1'b1;
        if (i_q == (AW+1)'(SieveSize - 1)) begin
          i_d = (AW+1)'(2); state_d = ST_SIEVE_SCAN;
        end
      end
      ST_SIEVE_SCAN: begin
        if ({{(32-AW-1){1'b0}}, i_q} * {{(32-AW-1){1'b0}}, i_q} >= 32'(SieveSize))
          state_d = ST_IDLE;
        else state_d = ST_SIEVE_CHECK;
      end
      ST_SIEVE_CHECK: begin
        if (rdata) begin
          j_d = (AW+1)'(i_q * i_q); state_d = ST_SIEVE_MARK;
        end else begin
          i_d = i_q + 1'b1; state_d = ST_SIEVE_SCAN;
        end
      end
      ST_SIEVE_MARK: begin
        if (j_q >= (AW+1)'(SieveSize)) begin
          i_d = i_q + 1'b1; state_d = ST_SIEVE_SCAN;
        end else begin
          we = 1'b1; addr = j_q[AW-1:0]; j_d = j_q + i_q;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        addr = number_i[AW-1:0];
        if (in_valid_i) begin
          num_d = number_i; oor_d = 1'b0; prime_d = 1'b0; rnd_d = 2'd0;
          cmd_o.load = 1'b1;
          if (number_i < 32'(SieveSize)) state_d = ST_LOOKUP;
          else if (number_i >= LimitFour) begin oor_d = 1'b1; state_d = ST_OUT; end
          else state_d = ST_ROUND_START;
        end
      end
      ST_LOOKUP: begin
        prime_d = rdata; state_d = ST_OUT;
      end
      ST_ROUND_START: begin
        cmd_o.start_round = 1'b1;
        case (rnd_q)
          2'd0: cmd_o.witness = 3'd2;
          2'd1: cmd_o.witness = 3'd3;
          2'd2: cmd_o.witness = 3'd5;
          default: cmd_o.witness = 3'd7;
        endcase
        state_d = ST_POW;
      end
      ST_POW: begin
        if (!sts_i.busy) begin
          if (sts_i.pow_done) begin
            if (sts_i.y_pass) state_d = ST_DONE;
            else state_d = ST_SQUARE;
          end else cmd_o.pow_step = 1'b1;
        end
      end
      ST_SQUARE: begin
        if (!sts_i.busy) begin
          if (sts_i.y_minus1) state_d = ST_DONE;
          else if (sts_i.s_zero) begin prime_d = 1'b0; state_d = ST_OUT; end
          else cmd_o.sq_step = 1'b1;
        end
      end
      ST_DONE: begin
        // Round passed: decide or move to the next witness.
        if ((rnd_q == 2'd1 && num_q < LimitTwo) || (rnd_q == 2'd2 && num_q < LimitThree)
            || rnd_q == 2'd3) begin
          prime_d = 1'b1; state_d = ST_OUT;
        end else begin
          rnd_d = rnd_q + 2'd1; state_d = ST_ROUND_START;
        end
      end
      ST_OUT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; i_q <= '0; j_q <= '0; rnd_q <= '0;
      prime_q <= 1'b0; oor_q <= 1'b0;
    end else begin
      state_q <= state_d; i_q <= i_d; j_q <= j_d; rnd_q <= rnd_d;
      prime_q <= prime_d; oor_q <= oor_d;
    end
  end
  always_ff @(posedge clk_i) num_q <= num_d;

  assign out_valid_o = (state_q == ST_OUT);
  assign is_prime_o = prime_q;
  assign out_of_range_o = oor_q;

  `PT_ASSERT_IMP(a_oor_not_prime, out_valid_o && out_of_range_o, !is_prime_o,
    "out-of-range result claims prime")
  `PT_ASSERT_NEXT(a_out_holds, out_valid_o && !out_ready_i, out_valid_o,
    "result dropped before taken")
  `PT_ASSERT_IMP(a_no_accept_busy, in_ready_o, !out_valid_o,
    "input taken while result pending")
endmodule
`default_nettype wire

// File: rtl/prime_test_32bit.sv
// Top level of the 32-bit prime tester; depends on pt_pkg, pt_if, pt_ctrl and pt_datapath.
// After reset the sieve is filled first, and no request is taken until the fill is done.
// Table numbers answer through ST_LOOKUP into ST_OUT, out-of-range ones go straight to ST_OUT;
// Miller-Rabin runs every modular multiply on the shared unit. One item at a time: the next
// is taken only once the result has been taken; reset asynchronous, low.
`default_nettype none
module prime_test_32bit #(
  parameter int unsigned SieveSize = pt_pkg::SieveSize
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  pt_if.sink       in_if,
  pt_if.source     out_if
);
  import pt_pkg::*;
  dp_cmd_t cmd;
  dp_sts_t sts;

  pt_ctrl #(.SieveSize(SieveSize)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .number_i(in_if.data), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .is_prime_o(out_if.data[0]), .out_of_range_o(out_if.data[1]),
    .cmd_o(cmd), .sts_i(sts)
  );

  pt_datapath u_dp (
    .clk_i, .rst_ni, .number_i(in_if.data), .cmd_i(cmd), .sts_o(sts)
  );
endmodule
`default_nettype wire
